@@ rtl/edf_pkg.sv @@
`default_nettype none
package edf_pkg;

    localparam int MAX_TASKS = 8;
    localparam int ID_W      = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS) + 1;

    localparam logic [15:0] IDLE_PERIOD = 16'hFFFF;
    localparam logic [15:0] IDLE_BUDGET = 16'hFFFF;
    localparam logic [15:0] USED_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        ACT_CREATE  = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_BLOCK   = 2'd2,
        ACT_UNBLOCK = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_DONE    = 2'd2,
        ST_BLOCKED = 2'd3
    } task_state_t;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_FULL    = 2'd1,
        ERR_EMPTY   = 2'd2,
        ERR_BAD_ST  = 2'd3
    } err_t;

    // Remainder unit handshake
    typedef struct packed {
        logic        start;
        logic [7:0]  dividend;
        logic [15:0] divisor;
    } rem_ctl_t;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_sts_t;

endpackage
`default_nettype wire

@@ rtl/edf_task_scheduler.sv @@
`default_nettype none
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    action task_id priority_req budget period
// out       output     out_valid/out_ready  switched running_task assigned_id error tick_count
//
// An insertion scans the ready queue one entry per cycle through the shared
// deadline comparator. A tick walks the done tasks through the shared 8-step
// remainder unit, re-inserts each released task, then checks budget and preemption.
// Reset clears the tick count, queues and task states; no clearing pass.
// A result waits in the output register while the next item is taken.
module edf_task_scheduler (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [2:0]  task_id,
    input  wire logic [7:0]  priority_req,
    input  wire logic [15:0] budget,
    input  wire logic [15:0] period,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             switched,
    output logic [2:0]       running_task,
    output logic [2:0]       assigned_id,
    output logic [1:0]       error,
    output logic [7:0]       tick_count
);
    import edf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_REL_NEXT = 7'b0000010,
        S_REL_WAIT = 7'b0000100,
        S_SCAN     = 7'b0001000,
        S_DECIDE   = 7'b0010000,
        S_PREEMPT  = 7'b0100000,
        S_OUT      = 7'b1000000
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;

    logic [7:0]       tick_reg, tick_next;
    logic [ID_W-1:0]  cur_reg, cur_next, prev_reg, prev_next;
    logic [CNT_W-1:0] created_reg, created_next;
    logic [CNT_W-1:0] rc_reg, rc_next, dc_reg, dc_next;
    logic [CNT_W-1:0] pos_reg, pos_next, ri_reg, ri_next, keep_reg, keep_next;
    logic [ID_W-1:0]  ins_reg, ins_next, rel_reg, rel_next;
    logic [1:0]       err_reg, err_next;
    logic [ID_W-1:0]  asg_reg, asg_next;

    task_state_t      status_reg [MAX_TASKS];
    task_state_t      status_next [MAX_TASKS];
    logic [15:0]      used_reg [MAX_TASKS];
    logic [15:0]      used_next [MAX_TASKS];
    logic [ID_W-1:0]  ro_reg [MAX_TASKS];
    logic [ID_W-1:0]  ro_next [MAX_TASKS];
    logic [ID_W-1:0]  do_reg [MAX_TASKS];

    logic [7:0]       prio_mem [MAX_TASKS];
    logic [15:0]      bud_mem [MAX_TASKS];
    logic [15:0]      per_mem [MAX_TASKS];

    logic             tbl_we;
    logic [ID_W-1:0]  tbl_wa;
    logic             do_we;
    logic [ID_W-1:0]  do_wa, do_wd;

    logic             out_valid_reg, out_valid_next;
    logic             sw_reg, sw_next;
    logic [2:0]       run_o_reg, run_o_next, asg_o_reg, asg_o_next;
    logic [1:0]       err_o_reg, err_o_next;
    logic [7:0]       tick_o_reg, tick_o_next;

    logic [ID_W-1:0]  cmp_a, cmp_b;
    logic [15:0]      per_a, per_b;
    logic [7:0]       prio_a, prio_b;
    logic             a_before_b;
    logic [15:0]      used_inc, cur_budget;
    logic [ID_W-1:0]  head;

    rem_ctl_t         rem_ctl;
    rem_sts_t         rem_sts;

    edf_rem_unit u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rem_ctl),
        .sts   (rem_sts)
    );

    assign head = ro_reg[0];

    // Shared deadline comparator: a stands before b
    always_comb
    begin
        if (state_reg == S_SCAN)
        begin
            cmp_a = ins_reg;
            cmp_b = ro_reg[pos_reg[ID_W-1:0]];
        end
        else
        begin
            cmp_a = cur_reg;
            cmp_b = head;
        end
        per_a  = (cmp_a == '0) ? IDLE_PERIOD : per_mem[cmp_a];
        per_b  = (cmp_b == '0) ? IDLE_PERIOD : per_mem[cmp_b];
        prio_a = (cmp_a == '0) ? 8'd0 : prio_mem[cmp_a];
        prio_b = (cmp_b == '0) ? 8'd0 : prio_mem[cmp_b];
        if (per_a != per_b)
            a_before_b = per_a < per_b;
        else
            a_before_b = prio_a >= prio_b;
    end

    assign cur_budget = (cur_reg == '0) ? IDLE_BUDGET : bud_mem[cur_reg];
    assign used_inc   = (used_reg[cur_reg] == USED_MAX) ? USED_MAX
                                                        : used_reg[cur_reg] + 16'd1;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        tick_next    = tick_reg;
        cur_next     = cur_reg;
        prev_next    = prev_reg;
        created_next = created_reg;
        rc_next      = rc_reg;
        dc_next      = dc_reg;
        pos_next     = pos_reg;
        ri_next      = ri_reg;
        keep_next    = keep_reg;
        ins_next     = ins_reg;
        rel_next     = rel_reg;
        err_next     = err_reg;
        asg_next     = asg_reg;
        status_next  = status_reg;
        used_next    = used_reg;
        ro_next      = ro_reg;
        tbl_we       = 1'b0;
        tbl_wa       = created_reg[ID_W-1:0];
        do_we        = 1'b0;
        do_wa        = keep_reg[ID_W-1:0];
        do_wd        = rel_reg;
        rem_ctl.start    = 1'b0;
        rem_ctl.dividend = tick_reg;
        rem_ctl.divisor  = per_mem[do_reg[ri_reg[ID_W-1:0]]];
        out_valid_next = out_valid_reg && !out_ready;
        sw_next        = sw_reg;
        run_o_next     = run_o_reg;
        asg_o_next     = asg_o_reg;
        err_o_next     = err_o_reg;
        tick_o_next    = tick_o_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    prev_next = cur_reg;
                    err_next  = ERR_NONE;
                    asg_next  = '0;
                    pos_next  = '0;
                    ret_next  = S_OUT;
                    state_next = S_OUT;
                    case (action_t'(action))
                        ACT_CREATE:
                        begin
                            if (created_reg >= CNT_W'(MAX_TASKS))
                                err_next = ERR_FULL;
                            else
                            begin
                                tbl_we       = 1'b1;
                                used_next[created_reg[ID_W-1:0]] = 16'd0;
                                ins_next     = created_reg[ID_W-1:0];
                                asg_next     = created_reg[ID_W-1:0];
                                created_next = created_reg + CNT_W'(1);
                                state_next   = S_SCAN;
                            end
                        end
                        ACT_TICK:
                        begin
                            tick_next  = tick_reg + 8'd1;
                            ri_next    = '0;
                            keep_next  = '0;
                            state_next = S_REL_NEXT;
                        end
                        ACT_BLOCK:
                        begin
                            if (cur_reg == '0 || status_reg[cur_reg] != ST_RUNNING)
                                err_next = ERR_BAD_ST;
                            else
                                status_next[cur_reg] = ST_BLOCKED;
                        end
                        ACT_UNBLOCK:
                        begin
                            if ({1'b0, task_id} >= created_reg
                                || status_reg[task_id] != ST_BLOCKED)
                                err_next = ERR_BAD_ST;
                            else if (task_id == cur_reg)
                                status_next[task_id] = ST_RUNNING;
                            else
                            begin
                                ins_next   = task_id;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            err_next = ERR_NONE;
                        end
                    endcase
                end
            end

            // Release done tasks in FIFO order
            S_REL_NEXT:
            begin
                if (ri_reg < dc_reg)
                begin
                    rel_next      = do_reg[ri_reg[ID_W-1:0]];
                    rem_ctl.start = 1'b1;
                    state_next    = S_REL_WAIT;
                end
                else
                begin
                    dc_next    = keep_reg;
                    state_next = S_DECIDE;
                end
            end

            S_REL_WAIT:
            begin
                if (rem_sts.done)
                begin
                    ri_next = ri_reg + CNT_W'(1);
                    if (rem_sts.zero)
                    begin
                        ins_next   = rel_reg;
                        pos_next   = '0;
                        ret_next   = S_REL_NEXT;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        do_we      = 1'b1;
                        keep_next  = keep_reg + CNT_W'(1);
                        state_next = S_REL_NEXT;
                    end
                end
            end

            // Find the slot one entry per cycle, then insert
            S_SCAN:
            begin
                if (rc_reg >= CNT_W'(MAX_TASKS))
                    state_next = ret_reg;
                else if (pos_reg < rc_reg && !a_before_b)
                    pos_next = pos_reg + CNT_W'(1);
                else
                begin
                    for (int j = 0; j < MAX_TASKS; j++)
                    begin
                        if (CNT_W'(j) == pos_reg)
                            ro_next[j] = ins_reg;
                        else if (CNT_W'(j) > pos_reg && j > 0)
                            ro_next[j] = ro_reg[j-1];
                    end
                    rc_next = rc_reg + CNT_W'(1);
                    status_next[ins_reg] = ST_READY;
                    state_next = ret_reg;
                end
            end

            S_DECIDE:
            begin
                state_next = S_OUT;
                if (status_reg[cur_reg] == ST_BLOCKED)
                begin
                    if (rc_reg == '0)
                        err_next = ERR_EMPTY;
                    else
                    begin
                        cur_next = head;
                        status_next[head] = ST_RUNNING;
                        for (int j = 0; j < MAX_TASKS - 1; j++)
                            ro_next[j] = ro_reg[j+1];
                        rc_next = rc_reg - CNT_W'(1);
                    end
                end
                else if (cur_reg != '0 && used_inc >= cur_budget)
                begin
                    if (rc_reg == '0)
                    begin
                        err_next = ERR_EMPTY;
                        used_next[cur_reg] = used_inc;
                    end
                    else
                    begin
                        used_next[cur_reg] = 16'd0;
                        cur_next = head;
                        status_next[head]    = ST_RUNNING;
                        status_next[cur_reg] = ST_DONE;
                        for (int j = 0; j < MAX_TASKS - 1; j++)
                            ro_next[j] = ro_reg[j+1];
                        rc_next = rc_reg - CNT_W'(1);
                        if (dc_reg < CNT_W'(MAX_TASKS))
                        begin
                            do_we   = 1'b1;
                            do_wa   = dc_reg[ID_W-1:0];
                            do_wd   = cur_reg;
                            dc_next = dc_reg + CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    if (cur_reg != '0)
                        used_next[cur_reg] = used_inc;
                    if (rc_reg != '0)
                        state_next = S_PREEMPT;
                end
            end

            // Strictly more urgent head takes over
            S_PREEMPT:
            begin
                state_next = S_OUT;
                if (!a_before_b)
                begin
                    cur_next = head;
                    status_next[head] = ST_RUNNING;
                    for (int j = 0; j < MAX_TASKS - 1; j++)
                        ro_next[j] = ro_reg[j+1];
                    rc_next    = rc_reg - CNT_W'(1);
                    ins_next   = cur_reg;
                    pos_next   = '0;
                    ret_next   = S_OUT;
                    state_next = S_SCAN;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    sw_next        = (cur_reg != prev_reg);
                    run_o_next     = 3'(cur_reg);
                    asg_o_next     = 3'(asg_reg);
                    err_o_next     = err_reg;
                    tick_o_next    = tick_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_OUT;
            tick_reg      <= 8'd0;
            cur_reg       <= '0;
            prev_reg      <= '0;
            created_reg   <= CNT_W'(1);
            rc_reg        <= '0;
            dc_reg        <= '0;
            pos_reg       <= '0;
            ri_reg        <= '0;
            keep_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < MAX_TASKS; j++)
            begin
                status_reg[j] <= (j == 0) ? ST_RUNNING : ST_READY;
                used_reg[j]   <= 16'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            tick_reg      <= tick_next;
            cur_reg       <= cur_next;
            prev_reg      <= prev_next;
            created_reg   <= created_next;
            rc_reg        <= rc_next;
            dc_reg        <= dc_next;
            pos_reg       <= pos_next;
            ri_reg        <= ri_next;
            keep_reg      <= keep_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            used_reg      <= used_next;
        end
    end

    // Payload and table storage
    always_ff @(posedge clk)
    begin
        ins_reg    <= ins_next;
        rel_reg    <= rel_next;
        err_reg    <= err_next;
        asg_reg    <= asg_next;
        ro_reg     <= ro_next;
        sw_reg     <= sw_next;
        run_o_reg  <= run_o_next;
        asg_o_reg  <= asg_o_next;
        err_o_reg  <= err_o_next;
        tick_o_reg <= tick_o_next;
        if (do_we)
            do_reg[do_wa] <= do_wd;
        if (tbl_we)
        begin
            prio_mem[tbl_wa] <= priority_req;
            bud_mem[tbl_wa]  <= budget;
            per_mem[tbl_wa]  <= period;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign switched     = sw_reg;
    assign running_task = run_o_reg;
    assign assigned_id  = asg_o_reg;
    assign error        = err_o_reg;
    assign tick_count   = tick_o_reg;

    // Queue occupancy never exceeds the task table
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ({1'b0, rc_reg} + {1'b0, dc_reg} < {1'b0, created_reg}))
        else $error("ready plus done queues exceed created tasks");

    // Current task is running or blocked between items
    a_cur_state: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
        (status_reg[cur_reg] == ST_RUNNING || status_reg[cur_reg] == ST_BLOCKED))
        else $error("current task in wrong state");

    // Remainder results arrive only while the release walk waits
    a_rem_done: assert property (@(posedge clk) disable iff (!rst_n)
        rem_sts.done |-> (state_reg == S_REL_WAIT))
        else $error("unexpected remainder result");

    // Ticks bump the count by one
    a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && action == ACT_TICK) |=> (tick_reg == $past(tick_reg) + 8'd1))
        else $error("tick count did not advance");

endmodule
`default_nettype wire

@@ rtl/edf_rem_unit.sv @@
`default_nettype none
module edf_rem_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire edf_pkg::rem_ctl_t ctl,
    output edf_pkg::rem_sts_t     sts
);
    import edf_pkg::*;

    logic [15:0] rem_reg, rem_next;
    logic [15:0] div_reg, div_next;
    logic [7:0]  dvd_reg, dvd_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    // One restoring step per cycle, eight steps for the 8-bit dividend
    always_comb
    begin
        rem_next  = rem_reg;
        div_next  = div_reg;
        dvd_next  = dvd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[7]};
        if (ctl.start)
        begin
            rem_next  = 16'd0;
            div_next  = (ctl.divisor == 16'd0) ? 16'd1 : ctl.divisor;
            dvd_next  = ctl.dividend;
            cnt_next  = 4'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = 16'(trial - {1'b0, div_reg});
            else
                rem_next = trial[15:0];
            dvd_next = {dvd_reg[6:0], 1'b0};
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'd7)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        dvd_reg <= dvd_next;
    end

    assign sts.done = done_reg;
    assign sts.zero = (rem_reg == 16'd0);

endmodule
`default_nettype wire
